// File: sv/bmre_pkg.sv
// bmre_pkg: shared constants, record types and helpers for the rectangle extremes block
// no dependencies; used by the interfaces, bmre_best and binary_map_rectangle_extremes
package bmre_pkg;

  localparam int MAX_DIM = 64;
  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int RUN_W   = $clog2(MAX_DIM + 1);
  localparam int AREA_W  = 2 * RUN_W;

  localparam int CFG_W      = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int DIM_RESET  = 64;
  localparam int KIND_W     = 2;
  localparam int POS_W      = 6;
  localparam int LEN_W      = 7;
  localparam int AREA_OUT_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_WIDE = 2'd0,
    KIND_AREA = 2'd1,
    KIND_TALL = 2'd2
  } kind_t;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [RUN_W-1:0] wid;
    logic [RUN_W-1:0] hgt;
  } rect_t;

  typedef struct packed {
    logic  valid;
    rect_t rect;
  } cand_t;

  typedef struct packed {
    rect_t             rect;
    logic [AREA_W-1:0] area;
  } rec_t;

  function automatic logic [RUN_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [RUN_W-1:0] r;
    if (v == '0) begin
      r = RUN_W'(1);
    end else if (v > MAX_DIM) begin
      r = RUN_W'(MAX_DIM);
    end else begin
      r = RUN_W'(v);
    end
    return r;
  endfunction

endpackage

// File: sv/bmre_if.sv
// bmre_pixel_if and bmre_result_if: valid/ready channels of the rectangle extremes block
// depends on bmre_pkg for field widths
interface bmre_pixel_if;
  import bmre_pkg::*;
  logic valid;
  logic ready;
  logic pixel;
  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface bmre_result_if;
  import bmre_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [KIND_W-1:0]     kind;
  logic                  found;
  logic [POS_W-1:0]      top_row;
  logic [POS_W-1:0]      left_col;
  logic [LEN_W-1:0]      width;
  logic [LEN_W-1:0]      height;
  logic [AREA_OUT_W-1:0] area;
  logic                  last;
  modport source (output valid, output kind, output found, output top_row, output left_col,
                  output width, output height, output area, output last, input ready);
  modport sink (input valid, input kind, input found, input top_row, input left_col,
                input width, input height, input area, input last, output ready);
endinterface

// File: sv/binary_map_rectangle_extremes.sv
// binary_map_rectangle_extremes: loads a binary map, scans it for rectangle corners and
// reports the widest, largest-area and tallest rectangle; depends on bmre_pkg, bmre_if, bmre_best
//
//   channel   dir  beat                                  handshake
//   pixels    in   one map cell, row-major               valid/ready
//   results   out  kind, found, corner, runs, area, last valid/ready
//   cfg       in   row_count / column_count write        cfg_wr_en, no wait
//
// loading accepts one pixel per cycle while in the load state; each row is written to the map memory at its last column
// scan runs bottom-up; each row goes through S_RDCUR, S_GETCUR and S_GETUP for the map memory
// reads, then the column walk with a read-modify-write of the column height memory
// then the candidate pipeline drains and 1 or 3 result beats follow; pixels are refused from last pixel to
// the final result beat being loaded into the output register
// rst is synchronous; the map memory needs no clearing, only cells of the current frame are read
module binary_map_rectangle_extremes (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [bmre_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bmre_pkg::CFG_W-1:0]     cfg_data,
  bmre_pixel_if.sink                     pixels,
  bmre_result_if.source                  results
);
  import bmre_pkg::*;

  typedef enum logic [5:0] {
    S_LOAD   = 6'b000001,
    S_RDCUR  = 6'b000010,
    S_GETCUR = 6'b000100,
    S_GETUP  = 6'b001000,
    S_WALK   = 6'b010000,
    S_OUT    = 6'b100000
  } state_t;

  state_t state;

  logic [RUN_W-1:0] rows_c;
  logic [RUN_W-1:0] cols_c;
  logic [IDX_W-1:0] ld_row;
  logic [IDX_W-1:0] ld_col;
  logic [MAX_DIM-1:0] rowbuf;
  logic [MAX_DIM-1:0] row_word;

  logic [MAX_DIM-1:0] map_mem [MAX_DIM];
  logic [MAX_DIM-1:0] map_rdata;
  logic [IDX_W-1:0]   map_raddr;
  logic               map_we;

  logic [RUN_W-1:0] hc_mem [MAX_DIM];
  logic [RUN_W-1:0] hc_rdata;
  logic [IDX_W-1:0] hc_raddr;
  logic             hc_we;

  logic [IDX_W-1:0]   scan_row;
  logic [IDX_W-1:0]   walk_col;
  logic [IDX_W-1:0]   prev_col;
  logic [MAX_DIM-1:0] cur;
  logic [MAX_DIM-1:0] above;
  logic [RUN_W-1:0]   run_w;
  logic [RUN_W-1:0]   run_next;
  logic [RUN_W-1:0]   h_old;
  logic [RUN_W-1:0]   h_new;
  logic               cur_bit;
  logic               left_clear;
  logic               corner;
  logic               first_row;

  logic  cand_valid;
  rect_t cand_rect;
  cand_t cand;
  logic  best_busy;
  logic  any_found;
  rec_t  best [3];
  rec_t  sel;

  logic                  in_fire;
  logic                  last_col;
  logic                  last_row;
  logic                  load_beat;
  kind_t                 out_k;
  logic                  ovalid;
  kind_t                 o_kind;
  logic                  o_found;
  logic [POS_W-1:0]      o_top;
  logic [POS_W-1:0]      o_left;
  logic [LEN_W-1:0]      o_wid;
  logic [LEN_W-1:0]      o_hgt;
  logic [AREA_OUT_W-1:0] o_area;
  logic                  o_last;

  assign pixels.ready = (state == S_LOAD);
  assign in_fire      = pixels.valid && pixels.ready;
  assign last_col     = (RUN_W'(ld_col) + 1'b1) == cols_c;
  assign last_row     = (RUN_W'(ld_row) + 1'b1) == rows_c;
  assign map_we       = in_fire && last_col;

  always_comb begin
    row_word         = rowbuf;
    row_word[ld_col] = pixels.pixel;
  end

  always_comb begin
    case (state)
      S_GETCUR: map_raddr = scan_row - 1'b1;
      default:  map_raddr = scan_row;
    endcase
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[ld_row] <= row_word;
    end
    map_rdata <= map_mem[map_raddr];
  end

  // column walk, right to left
  assign prev_col   = walk_col - 1'b1;
  assign cur_bit    = cur[walk_col];
  assign left_clear = (walk_col == '0) || !cur[prev_col];
  assign corner     = cur_bit && !above[walk_col] && left_clear;
  assign run_next   = cur_bit ? run_w + 1'b1 : '0;
  assign first_row  = (RUN_W'(scan_row) + 1'b1) == rows_c;
  assign h_old      = first_row ? '0 : hc_rdata;
  assign h_new      = cur_bit ? h_old + 1'b1 : '0;
  assign hc_we      = (state == S_WALK);

  always_comb begin
    case (state)
      S_GETUP: hc_raddr = IDX_W'(cols_c - 1'b1);
      default: hc_raddr = prev_col;
    endcase
  end

  always_ff @(posedge clk) begin
    if (hc_we) begin
      hc_mem[walk_col] <= h_new;
    end
    hc_rdata <= hc_mem[hc_raddr];
  end

  assign cand = '{valid: cand_valid, rect: cand_rect};

  bmre_best u_best (
    .clk       (clk),
    .rst       (rst),
    .clear     (map_we && last_row),
    .cand      (cand),
    .busy      (best_busy),
    .any_found (any_found),
    .best      (best)
  );

  assign load_beat = (state == S_OUT) && !cand_valid && !best_busy &&
                     (!ovalid || results.ready);
  assign sel       = best[out_k];

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      rows_c     <= clamp_dim(CFG_W'(DIM_RESET));
      cols_c     <= clamp_dim(CFG_W'(DIM_RESET));
      ld_row     <= '0;
      ld_col     <= '0;
      scan_row   <= '0;
      walk_col   <= '0;
      out_k      <= KIND_WIDE;
      cand_valid <= 1'b0;
      ovalid     <= 1'b0;
    end else begin
      cand_valid <= (state == S_WALK) && corner;
      if (load_beat) begin
        ovalid <= 1'b1;
      end else if (results.ready) begin
        ovalid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (in_fire && !cfg_wr_en) begin
            if (last_col) begin
              ld_col <= '0;
              if (last_row) begin
                ld_row   <= '0;
                scan_row <= IDX_W'(rows_c - 1'b1);
                state    <= S_RDCUR;
              end else begin
                ld_row <= ld_row + 1'b1;
              end
            end else begin
              ld_col <= ld_col + 1'b1;
            end
          end
        end
        S_RDCUR: begin
          state <= S_GETCUR;
        end
        S_GETCUR: begin
          state <= S_GETUP;
        end
        S_GETUP: begin
          walk_col <= IDX_W'(cols_c - 1'b1);
          state    <= S_WALK;
        end
        S_WALK: begin
          if (walk_col == '0) begin
            if (scan_row == '0) begin
              state <= S_OUT;
            end else begin
              scan_row <= scan_row - 1'b1;
              state    <= S_RDCUR;
            end
          end else begin
            walk_col <= prev_col;
          end
        end
        S_OUT: begin
          if (load_beat) begin
            if (!any_found || out_k == KIND_TALL) begin
              out_k <= KIND_WIDE;
              state <= S_LOAD;
            end else begin
              out_k <= kind_t'(out_k + 1'b1);
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_ROW_COUNT: begin
            rows_c <= clamp_dim(cfg_data);
            ld_row <= '0;
            ld_col <= '0;
          end
          REG_COLUMN_COUNT: begin
            cols_c <= clamp_dim(cfg_data);
            ld_row <= '0;
            ld_col <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rowbuf[ld_col] <= pixels.pixel;
    end
    if (state == S_GETCUR) begin
      cur <= map_rdata;
    end
    if (state == S_GETUP) begin
      above <= (scan_row == '0) ? '0 : map_rdata;
      run_w <= '0;
    end
    if (state == S_WALK) begin
      run_w     <= run_next;
      cand_rect <= '{row: scan_row, col: walk_col, wid: run_next, hgt: h_new};
    end
    if (load_beat) begin
      o_kind <= out_k;
      if (any_found) begin
        o_found <= 1'b1;
        o_top   <= POS_W'(sel.rect.row);
        o_left  <= POS_W'(sel.rect.col);
        o_wid   <= LEN_W'(sel.rect.wid);
        o_hgt   <= LEN_W'(sel.rect.hgt);
        o_area  <= AREA_OUT_W'(sel.area);
        o_last  <= (out_k == KIND_TALL);
      end else begin
        o_found <= 1'b0;
        o_top   <= '0;
        o_left  <= '0;
        o_wid   <= '0;
        o_hgt   <= '0;
        o_area  <= '0;
        o_last  <= 1'b1;
      end
    end
  end

  assign results.valid    = ovalid;
  assign results.kind     = o_kind;
  assign results.found    = o_found;
  assign results.top_row  = o_top;
  assign results.left_col = o_left;
  assign results.width    = o_wid;
  assign results.height   = o_hgt;
  assign results.area     = o_area;
  assign results.last     = o_last;

`ifndef ASSERT_OFF
  a_notfound_last: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.found) |-> results.last)
    else $error("not-found beat without last");

  a_area_match: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.found) |->
      (results.area == AREA_OUT_W'(AREA_OUT_W'(results.width) * AREA_OUT_W'(results.height))))
    else $error("area does not match width times height");

  a_walk_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (RUN_W'(walk_col) < cols_c))
    else $error("column walk outside the map");

  a_cand_runs: assert property (@(posedge clk) disable iff (rst)
    cand_valid |-> ((cand_rect.wid != '0) && (cand_rect.hgt != '0)))
    else $error("corner candidate with empty run");
`endif

endmodule

// File: sv/bmre_best.sv
// bmre_best: area stage and running best widest / largest-area / tallest records
// depends on bmre_pkg; fed with corner candidates in reverse raster order
module bmre_best (
  input  logic            clk,
  input  logic            rst,
  input  logic            clear,
  input  bmre_pkg::cand_t cand,
  output logic            busy,
  output logic            any_found,
  output bmre_pkg::rec_t  best [3]
);
  import bmre_pkg::*;

  logic              s2_valid;
  rect_t             s2_rect;
  logic [AREA_W-1:0] s2_area;
  rec_t              s2_rec;

  assign busy   = s2_valid;
  assign s2_rec = '{rect: s2_rect, area: s2_area};

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      s2_valid  <= 1'b0;
      any_found <= 1'b0;
    end else begin
      s2_valid <= cand.valid;
      if (s2_valid) begin
        any_found <= 1'b1;
      end
    end
  end

  // reverse raster order: ties go to the later candidate
  always_ff @(posedge clk) begin
    s2_rect <= cand.rect;
    s2_area <= AREA_W'(cand.rect.wid) * AREA_W'(cand.rect.hgt);
    if (s2_valid) begin
      if (!any_found) begin
        best[KIND_WIDE] <= s2_rec;
        best[KIND_AREA] <= s2_rec;
        best[KIND_TALL] <= s2_rec;
      end else begin
        if (s2_rect.wid >= best[KIND_WIDE].rect.wid) begin
          best[KIND_WIDE] <= s2_rec;
        end
        if (s2_area >= best[KIND_AREA].area) begin
          best[KIND_AREA] <= s2_rec;
        end
        if (s2_rect.hgt >= best[KIND_TALL].rect.hgt) begin
          best[KIND_TALL] <= s2_rec;
        end
      end
    end
  end

endmodule

// File: bench/tb_binary_map_rectangle_extremes.sv
// tb_binary_map_rectangle_extremes: self-checking bench for the rectangle extremes block
// loads whole and cut-off maps, predicts widest / largest-area / tallest corners and checks beats
// depends on bmre_pkg, bmre_pixel_if, bmre_result_if and binary_map_rectangle_extremes
module tb_binary_map_rectangle_extremes;
  import bmre_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int LIMIT_CYCLES  = 600000;
  localparam int RANDOM_PIXELS = 150;
  localparam int RANDOM_FRAMES = 6;

  typedef struct packed {
    kind_t                 kind;
    logic                  found;
    logic [POS_W-1:0]      top_row;
    logic [POS_W-1:0]      left_col;
    logic [LEN_W-1:0]      width;
    logic [LEN_W-1:0]      height;
    logic [AREA_OUT_W-1:0] area;
    logic                  last;
  } extreme_t;

  class rect_board;
    bit               cells [MAX_DIM][MAX_DIM];
    logic [CFG_W-1:0] rows_reg;
    logic [CFG_W-1:0] cols_reg;
    int unsigned      filled;
    int               errors;
    extreme_t         pending_extremes [$];

    function new();
      rows_reg = CFG_W'(DIM_RESET);
      cols_reg = CFG_W'(DIM_RESET);
      filled   = 0;
      errors   = 0;
    endfunction

    static function int unsigned span(logic [CFG_W-1:0] v);
      if (v == '0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return 32'(v);
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      if (idx == REG_ROW_COUNT) begin
        rows_reg = value;
      end else begin
        cols_reg = value;
      end
      filled = 0;
    endfunction

    function void scan_frame(int unsigned nr, int unsigned nc);
      kind_t       order [3];
      int unsigned top [3];
      int unsigned left [3];
      int unsigned wid [3];
      int unsigned hgt [3];
      int unsigned w;
      int unsigned h;
      bit          any;
      extreme_t    beat;
      order[0] = KIND_WIDE;
      order[1] = KIND_AREA;
      order[2] = KIND_TALL;
      any = 1'b0;
      for (int unsigned r = 0; r < nr; r++) begin
        for (int unsigned c = 0; c < nc; c++) begin
          if (!cells[r][c] || (r > 0 && cells[r-1][c]) || (c > 0 && cells[r][c-1])) continue;
          w = 0;
          while (c + w < nc && cells[r][c + w]) w++;
          h = 0;
          while (r + h < nr && cells[r + h][c]) h++;
          for (int i = 0; i < 3; i++) begin
            if (!any || (i == 0 && w > wid[0]) || (i == 1 && w * h > wid[1] * hgt[1]) ||
                (i == 2 && h > hgt[2])) begin
              top[i]  = r;
              left[i] = c;
              wid[i]  = w;
              hgt[i]  = h;
            end
          end
          any = 1'b1;
        end
      end
      if (!any) begin
        beat      = '0;
        beat.kind = KIND_WIDE;
        beat.last = 1'b1;
        pending_extremes.push_back(beat);
        return;
      end
      for (int i = 0; i < 3; i++) begin
        beat.kind     = order[i];
        beat.found    = 1'b1;
        beat.top_row  = POS_W'(top[i]);
        beat.left_col = POS_W'(left[i]);
        beat.width    = LEN_W'(wid[i]);
        beat.height   = LEN_W'(hgt[i]);
        beat.area     = AREA_OUT_W'(wid[i] * hgt[i]);
        beat.last     = (i == 2);
        pending_extremes.push_back(beat);
      end
    endfunction

    function void note_pixel(bit p);
      int unsigned nr;
      int unsigned nc;
      nr = span(rows_reg);
      nc = span(cols_reg);
      if (filled >= nr * nc) filled = 0;
      cells[filled / nc][filled % nc] = p;
      filled++;
      if (filled == nr * nc) begin
        scan_frame(nr, nc);
        filled = 0;
      end
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $time, msg);
      errors++;
    endtask

    task compare(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_result(extreme_t got);
      extreme_t want;
      if (pending_extremes.size() == 0) begin
        report($sformatf("result beat with nothing pending, kind %0d", got.kind));
        return;
      end
      want = pending_extremes.pop_front();
      compare("kind", got.kind, want.kind);
      compare("found", got.found, want.found);
      compare("top_row", got.top_row, want.top_row);
      compare("left_col", got.left_col, want.left_col);
      compare("width", got.width, want.width);
      compare("height", got.height, want.height);
      compare("area", got.area, want.area);
      compare("last", got.last, want.last);
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  bmre_pixel_if  pixel_ch ();
  bmre_result_if result_ch ();

  binary_map_rectangle_extremes DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixels    (pixel_ch),
    .results   (result_ch)
  );

  rect_board        board;
  bit               frame_bits [MAX_DIM][MAX_DIM];
  logic [CFG_W-1:0] rows_raw = CFG_W'(DIM_RESET);
  logic [CFG_W-1:0] cols_raw = CFG_W'(DIM_RESET);
  bit               pixel_bursty = 1'b1;
  bit               reply_bursty = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #(LIMIT_CYCLES * 12);
    $display("tb_binary_map_rectangle_extremes: errors");
    $finish;
  end

  function automatic int draw_gap(bit bursty);
    return bursty ? 0 : $urandom_range(0, 18);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.set_register(idx, value);
    if (idx == REG_ROW_COUNT) begin
      rows_raw = value;
    end else begin
      cols_raw = value;
    end
  endtask

  task automatic set_dims(input logic [CFG_W-1:0] nr, input logic [CFG_W-1:0] nc);
    write_reg(REG_ROW_COUNT, nr);
    write_reg(REG_COLUMN_COUNT, nc);
  endtask

  // valid stays high across back-to-back beats
  task automatic push_pixel(input bit p);
    int gap;
    gap = draw_gap(pixel_bursty);
    if (gap > 0) begin
      pixel_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_ch.valid <= 1'b1;
    pixel_ch.pixel <= p;
    @(posedge clk);
    while (!pixel_ch.ready) @(posedge clk);
    board.note_pixel(p);
  endtask

  task automatic push_pixels(input int unsigned count);
    int unsigned nc;
    nc = rect_board::span(cols_raw);
    for (int unsigned i = 0; i < count; i++) push_pixel(frame_bits[i / nc][i % nc]);
  endtask

  task automatic push_frame();
    push_pixels(rect_board::span(rows_raw) * rect_board::span(cols_raw));
  endtask

  task automatic finish_frame();
    pixel_ch.valid <= 1'b0;
    while (board.pending_extremes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic fill_level(input int pct);
    for (int r = 0; r < MAX_DIM; r++) begin
      for (int c = 0; c < MAX_DIM; c++) frame_bits[r][c] = ($urandom_range(0, 99) < pct);
    end
  endtask

  task automatic set_row(input int r, input logic [3:0] v);
    for (int c = 0; c < 4; c++) frame_bits[r][c] = v[3 - c];
  endtask

  task automatic place_blocks();
    int unsigned nr;
    int unsigned nc;
    int unsigned t;
    int unsigned l;
    int unsigned h;
    int unsigned w;
    nr = rect_board::span(rows_raw);
    nc = rect_board::span(cols_raw);
    fill_level(0);
    repeat ($urandom_range(1, 4)) begin
      t = $urandom_range(0, nr - 1);
      l = $urandom_range(0, nc - 1);
      h = $urandom_range(1, nr - t);
      w = $urandom_range(1, nc - l);
      for (int unsigned r = t; r < t + h; r++) begin
        for (int unsigned c = l; c < l + w; c++) frame_bits[r][c] = 1'b1;
      end
    end
    if ($urandom_range(0, 1) == 1) begin
      t = $urandom_range(0, nr - 1);
      l = $urandom_range(0, nc - 1);
      frame_bits[t][l] = !frame_bits[t][l];
    end
  endtask

  // result side: random stalls, one check per accepted beat
  initial begin
    extreme_t got;
    int       gap;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = draw_gap(reply_bursty);
      if (gap > 0) begin
        result_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!result_ch.valid) @(posedge clk);
      got.kind     = kind_t'(result_ch.kind);
      got.found    = result_ch.found;
      got.top_row  = result_ch.top_row;
      got.left_col = result_ch.left_col;
      got.width    = result_ch.width;
      got.height   = result_ch.height;
      got.area     = result_ch.area;
      got.last     = result_ch.last;
      board.check_result(got);
    end
  end

  initial begin
    int unsigned      random_pixels;
    int unsigned      random_frames;
    int unsigned      total;
    int unsigned      count;
    logic [CFG_W-1:0] nr;
    logic [CFG_W-1:0] nc;
    pixel_ch.valid <= 1'b0;
    pixel_ch.pixel <= 1'b0;
    board = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // single cell: empty map, then one set cell
    pixel_bursty = 1'b0;
    reply_bursty = 1'b1;
    set_dims(1, 1);
    fill_level(0);
    push_frame();
    finish_frame();
    frame_bits[0][0] = 1'b1;
    push_frame();
    finish_frame();

    // zero rows acts as one row; a full row
    reply_bursty = 1'b0;
    set_dims(0, 64);
    fill_level(100);
    push_frame();
    finish_frame();

    // oversized rows and zero columns: corner in the last row
    pixel_bursty = 1'b1;
    set_dims(127, 0);
    fill_level(0);
    frame_bits[63][0] = 1'b1;
    push_frame();
    finish_frame();

    // ties keep the first corner; corners with uneven runs
    pixel_bursty = 1'b0;
    set_dims(3, 4);
    fill_level(0);
    set_row(0, 4'b1011);
    set_row(2, 4'b1100);
    push_frame();
    finish_frame();
    set_row(0, 4'b1110);
    set_row(1, 4'b1001);
    set_row(2, 4'b1011);
    push_frame();
    finish_frame();

    // register writes in the middle of a map restart the map
    set_dims(2, 3);
    fill_level(50);
    push_pixels(4);
    finish_frame();
    write_reg(REG_COLUMN_COUNT, 3);
    fill_level(50);
    push_frame();
    finish_frame();
    push_pixels(2);
    finish_frame();
    write_reg(REG_ROW_COUNT, 1);
    fill_level(100);
    push_frame();
    finish_frame();

    random_pixels = 0;
    random_frames = 0;
    while (random_pixels < RANDOM_PIXELS || random_frames < RANDOM_FRAMES) begin
      case ($urandom_range(0, 9))
        0: begin
          nr = CFG_W'($urandom_range(17, 127));
          nc = CFG_W'($urandom_range(0, 2));
        end
        1: begin
          nr = CFG_W'($urandom_range(0, 2));
          nc = CFG_W'($urandom_range(17, 127));
        end
        2: begin
          nr = CFG_W'($urandom_range(0, 3));
          nc = CFG_W'($urandom_range(0, 3));
        end
        default: begin
          nr = CFG_W'($urandom_range(1, 6));
          nc = CFG_W'($urandom_range(1, 8));
        end
      endcase
      set_dims(nr, nc);
      pixel_bursty = ($urandom_range(0, 3) == 0);
      reply_bursty = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 5))
        0, 1: fill_level($urandom_range(0, 100));
        5: fill_level($urandom_range(0, 1) * 100);
        default: place_blocks();
      endcase
      total = rect_board::span(nr) * rect_board::span(nc);
      if (total > 1 && $urandom_range(0, 7) == 0) begin
        count = $urandom_range(1, total - 1);
      end else begin
        count = total;
        random_frames++;
      end
      push_pixels(count);
      random_pixels += count;
      finish_frame();
    end

    if (board.errors == 0) begin
      $display("tb_binary_map_rectangle_extremes: clean");
    end else begin
      $display("tb_binary_map_rectangle_extremes: errors");
    end
    $finish;
  end

endmodule
